/* hw/rtl/gcr62_pkg.sv */
package gcr62_pkg;

   localparam int unsigned AuxCount = 86;
   localparam int unsigned DataEnd  = 342;
   localparam int unsigned IdlePos  = 343;

   localparam logic [8:0] AuxCountPos = 9'(AuxCount);
   localparam logic [8:0] DataEndPos  = 9'(DataEnd);
   localparam logic [8:0] IdlePosPos  = 9'(IdlePos);
   localparam logic [7:0] GroupOneLo  = 8'(AuxCount);
   localparam logic [7:0] GroupTwoLo  = 8'(2 * AuxCount);

   localparam int unsigned AuxAddrWidth = $clog2(AuxCount);

   typedef logic [AuxAddrWidth-1:0] aux_addr_type;

   typedef enum logic [1:0] {
      GROUP_LOW  = 2'd0,
      GROUP_MID  = 2'd1,
      GROUP_HIGH = 2'd2,
      GROUP_NONE = 2'd3
   } group_type;

   typedef struct packed {
      logic [5:0] six;
      group_type  group;
      logic [7:0] index;
   } item_type;

   localparam logic [7:0] GcrCodes [64] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

   // Codes missing from the table decode to zero.
   function automatic logic [5:0] code_to_six(input logic [6:0] code);
      logic [5:0] value;
      value = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (GcrCodes[i][6:0] == code) begin
            value = 6'(i);
         end
      end
      return value;
   endfunction

endpackage

/* hw/rtl/gcr62_aux_ram.sv */
module gcr62_aux_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  gcr62_pkg::aux_addr_type wr_addr,
   input  logic [5:0]             wr_data,
   input  logic                   rd_en,
   input  gcr62_pkg::aux_addr_type rd_addr,
   output logic [5:0]             rd_data
);
   import gcr62_pkg::*;

   logic [5:0] mem [AuxCount];
   logic [5:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/gcr62_emit.sv */
module gcr62_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                item_valid,
   input  gcr62_pkg::item_type item,
   input  logic [5:0]          aux_data,
   output logic                take_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // data_byte [7:0], byte_index [15:8]
   output logic                rsp_tlast    // last_byte
);
   import gcr62_pkg::*;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   item_type   s1_item_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic [7:0] out_byte_in;
   logic [7:0] out_index_ff;
   logic       out_last_ff;
   logic       out_ready;
   logic       s1_move;
   logic [1:0] low_pair;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_ready;
   assign take_ready = !s1_valid_ff || out_ready;

   always_comb begin
      unique case (s1_item_ff.group)
         GROUP_LOW:  low_pair = {aux_data[0], aux_data[1]};
         GROUP_MID:  low_pair = {aux_data[2], aux_data[3]};
         GROUP_HIGH: low_pair = {aux_data[4], aux_data[5]};
         default:    low_pair = 2'b00;
      endcase
      out_byte_in = {s1_item_ff.six, low_pair};
   end

   always_comb begin
      if (load) begin
         s1_valid_in = item_valid;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_item_ff <= item;
      end
      if (s1_move) begin
         out_byte_ff  <= out_byte_in;
         out_index_ff <= s1_item_ff.index;
         out_last_ff  <= (s1_item_ff.index == 8'hFF);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_index_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;

   a_move_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> out_valid_ff)
      else $error("Staged byte was not placed in the output register.");

   a_no_load_while_blocked: assert property (@(posedge clock) disable iff (reset)
      load |-> take_ready)
      else $error("Stage loaded while it could not move on.");

   a_staged_group_valid: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_item_ff.group != GROUP_NONE))
      else $error("Staged byte carries no bit pair group.");

endmodule

/* hw/rtl/gcr_six_and_two_sector_decoder_unit.sv */
// Six-and-two GCR sector decoder.
// The req channel carries the disk bytes of a sector data field, one per transaction:
// tdata holds the disk byte (bit 7 is ignored) and tuser is high on the first of the
// 343 bytes of a sector. The first 86 bytes fill the auxiliary store and give no
// result, the next 256 each give one sector byte on the rsp channel, with its index
// in the upper half of tdata and tlast high on byte 255, and the checksum byte and any
// bytes after it up to the next sector start are consumed without a result.
// Throughput is one disk byte per clock cycle while the receiver does not stall: each
// byte needs one table lookup, one XOR with the chain register and at most one access
// to the auxiliary memory. A result moves from the stage register to the output
// register. When the receiver stalls, the output register and the stage before it
// keep their bytes and req_tready falls only once both are full.
// After reset the position and chain are cleared, so the first byte counts as a
// sector start; the auxiliary memory is not cleared, as every entry is written in a
// sector before it is read.
module gcr_six_and_two_sector_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // disk_code [7:0]
   input  logic [0:0]  req_tuser,   // first_of_sector [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // data_byte [7:0], byte_index [15:8]
   output logic        rsp_tlast    // last_byte
);
   import gcr62_pkg::*;

   logic [8:0]   pos_ff;
   logic [8:0]   pos_in;
   logic [5:0]   chain_ff;
   logic [5:0]   chain_in;
   logic         req_fire;
   logic         take_ready;
   logic [8:0]   pos_now;
   logic [5:0]   chain_now;
   logic         active;
   logic         aux_phase;
   logic [5:0]   six;
   logic [8:0]   k_full;
   logic [7:0]   k;
   group_type    group;
   logic [7:0]   aux_off;
   aux_addr_type rd_addr;
   logic         wr_en;
   logic         rd_en;
   logic [5:0]   aux_data;
   item_type     item;

   assign req_tready = take_ready;
   assign req_fire   = req_tvalid && take_ready;

   always_comb begin
      pos_now   = req_tuser[0] ? 9'd0 : pos_ff;
      chain_now = req_tuser[0] ? 6'd0 : chain_ff;
      active    = (pos_now < DataEndPos);
      aux_phase = (pos_now < AuxCountPos);
      six       = code_to_six(req_tdata[6:0]) ^ chain_now;
      k_full    = pos_now - AuxCountPos;
      k         = k_full[7:0];
      if (k < GroupOneLo) begin
         group   = GROUP_LOW;
         aux_off = k;
      end else if (k < GroupTwoLo) begin
         group   = GROUP_MID;
         aux_off = k - GroupOneLo;
      end else begin
         group   = GROUP_HIGH;
         aux_off = k - GroupTwoLo;
      end
      rd_addr = aux_off[AuxAddrWidth-1:0];
      wr_en   = req_fire && active && aux_phase;
      rd_en   = req_fire && active && !aux_phase;
      item    = '{six: six, group: group, index: k};
   end

   always_comb begin
      pos_in   = pos_ff;
      chain_in = chain_ff;
      if (req_fire) begin
         if (active) begin
            pos_in   = pos_now + 9'd1;
            chain_in = six;
         end else begin
            pos_in   = IdlePosPos;
            chain_in = chain_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 9'd0;
         chain_ff <= 6'd0;
      end else begin
         pos_ff   <= pos_in;
         chain_ff <= chain_in;
      end
   end

   gcr62_aux_ram u_aux_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_now[AuxAddrWidth-1:0]),
      .wr_data (six),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (aux_data)
   );

   gcr62_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .item_valid (rd_en),
      .item       (item),
      .aux_data   (aux_data),
      .take_ready (take_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= IdlePosPos)
      else $error("Sector position ran past the idle position.");

   a_single_port_access: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("Auxiliary memory written and read in the same cycle.");

   a_chain_held_when_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !active) |=> (chain_ff == $past(chain_now)))
      else $error("Chain value changed on a checksum or idle byte.");

endmodule
